// File: design/pelts_pkg.sv
package pelts_pkg;

  // Widths fixed by the item format
  localparam int unsigned TickW          = 8;
  localparam int unsigned ServedW        = 16;
  localparam int unsigned PressCountBits = 16;
  localparam int unsigned CfgIdxW        = 1;

  // Register reset values
  localparam logic [TickW-1:0] ShortTicksRst = 8'd6;
  localparam logic [TickW-1:0] LongTicksRst  = 8'd11;

  // Vehicle light codes
  localparam logic [1:0] LIGHT_RED   = 2'd0;
  localparam logic [1:0] LIGHT_AMBER = 2'd1;
  localparam logic [1:0] LIGHT_GREEN = 2'd2;
  localparam logic [1:0] LIGHT_FLASH = 2'd3;

  // Pedestrian light codes
  localparam logic [1:0] WALK_RED   = 2'd0;
  localparam logic [1:0] WALK_GREEN = 2'd1;
  localparam logic [1:0] WALK_FLASH = 2'd2;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SHORT_TICKS = 1'b0,
    CFG_LONG_TICKS  = 1'b1
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_VIA_AMBER  = 4'd1,
    PH_VIA_CROSS  = 4'd2,
    PH_VIA_FLASH  = 4'd3,
    PH_PARK_HOLD  = 4'd4,
    PH_PARK_CROSS = 4'd5,
    PH_PARK_FLASH = 4'd6,
    PH_EXIT_AMBER = 4'd7,
    PH_EXIT_GO    = 4'd8,
    PH_EXIT_FLASH = 4'd9
  } phase_e;

  typedef struct packed {
    logic press_via;
    logic press_parking;
    logic car_exit;
  } in_t;

  typedef struct packed {
    logic [1:0]         via_light;
    logic [1:0]         parking_light;
    logic [1:0]         walk_parking_light;
    logic [1:0]         walk_via_light;
    logic [TickW-1:0]   ticks_left;
    logic [ServedW-1:0] served_presses;
    logic               busy_res;
  } out_t;

  typedef struct packed {
    logic [1:0] via;
    logic [1:0] parking;
    logic [1:0] walk_parking;
    logic [1:0] walk_via;
  } lights_t;

  // Light pattern shown during each phase
  function automatic lights_t phase_lights(phase_e ph);
    lights_t l;
    case (ph)
      PH_VIA_AMBER:  l = '{LIGHT_AMBER, LIGHT_RED,   WALK_RED,   WALK_RED};
      PH_VIA_CROSS:  l = '{LIGHT_RED,   LIGHT_GREEN, WALK_RED,   WALK_GREEN};
      PH_VIA_FLASH:  l = '{LIGHT_FLASH, LIGHT_AMBER, WALK_RED,   WALK_FLASH};
      PH_PARK_HOLD:  l = '{LIGHT_GREEN, LIGHT_RED,   WALK_RED,   WALK_RED};
      PH_PARK_CROSS: l = '{LIGHT_GREEN, LIGHT_RED,   WALK_GREEN, WALK_RED};
      PH_PARK_FLASH: l = '{LIGHT_GREEN, LIGHT_FLASH, WALK_FLASH, WALK_RED};
      PH_EXIT_AMBER: l = '{LIGHT_AMBER, LIGHT_RED,   WALK_RED,   WALK_RED};
      PH_EXIT_GO:    l = '{LIGHT_RED,   LIGHT_GREEN, WALK_RED,   WALK_RED};
      PH_EXIT_FLASH: l = '{LIGHT_FLASH, LIGHT_AMBER, WALK_RED,   WALK_RED};
      default:       l = '{LIGHT_GREEN, LIGHT_RED,   WALK_RED,   WALK_RED};
    endcase
    return l;
  endfunction

  // Crossing phases and the car exit go phase take the long length
  function automatic logic phase_is_long(phase_e ph);
    return (ph == PH_VIA_CROSS) || (ph == PH_PARK_CROSS) || (ph == PH_EXIT_GO);
  endfunction

endpackage

// File: design/pelts_seq.sv
module pelts_seq #(
  parameter int unsigned PRESS_COUNT_BITS = pelts_pkg::PressCountBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         step_i,
  input  pelts_pkg::in_t               item_i,
  input  logic [pelts_pkg::TickW-1:0]  short_ticks_i,
  input  logic [pelts_pkg::TickW-1:0]  long_ticks_i,
  output pelts_pkg::out_t              res_o
);

  localparam logic [PRESS_COUNT_BITS-1:0] CntMax = '1;

  pelts_pkg::phase_e             phase_q, phase_d, target;
  logic [pelts_pkg::TickW-1:0]   count_q, count_d, len;
  logic                          pend_via_q, pend_via_d;
  logic                          pend_park_q, pend_park_d;
  logic [PRESS_COUNT_BITS-1:0]   total_q, total_d;
  logic [PRESS_COUNT_BITS:0]     total_sum;
  logic [1:0]                    add;
  logic                          enter;
  pelts_pkg::lights_t            lights;

  // Pick the phase that follows a finished one
  always_comb begin
    case (phase_q)
      pelts_pkg::PH_VIA_AMBER:  target = pelts_pkg::PH_VIA_CROSS;
      pelts_pkg::PH_VIA_CROSS:  target = pelts_pkg::PH_VIA_FLASH;
      pelts_pkg::PH_VIA_FLASH:
        target = pend_park_q ? pelts_pkg::PH_PARK_HOLD : pelts_pkg::PH_IDLE;
      pelts_pkg::PH_PARK_HOLD:  target = pelts_pkg::PH_PARK_CROSS;
      pelts_pkg::PH_PARK_CROSS: target = pelts_pkg::PH_PARK_FLASH;
      pelts_pkg::PH_EXIT_AMBER: target = pelts_pkg::PH_EXIT_GO;
      pelts_pkg::PH_EXIT_GO:    target = pelts_pkg::PH_EXIT_FLASH;
      pelts_pkg::PH_EXIT_FLASH: begin
        if (pend_via_q) begin
          target = pelts_pkg::PH_VIA_AMBER;
        end else if (pend_park_q) begin
          target = pelts_pkg::PH_PARK_HOLD;
        end else begin
          target = pelts_pkg::PH_IDLE;
        end
      end
      default: target = pelts_pkg::PH_IDLE;
    endcase
  end

  // Saturating count of served presses
  assign add       = {1'b0, item_i.press_via} + {1'b0, item_i.press_parking};
  assign total_sum = {1'b0, total_q} + (PRESS_COUNT_BITS + 1)'(add);

  // Advance one tick
  always_comb begin
    phase_d     = phase_q;
    count_d     = count_q;
    pend_via_d  = pend_via_q;
    pend_park_d = pend_park_q;
    total_d     = total_q;
    enter       = 1'b0;
    len         = '0;
    if (phase_q == pelts_pkg::PH_IDLE) begin
      if (item_i.press_via || item_i.press_parking) begin
        enter       = 1'b1;
        total_d     = total_sum[PRESS_COUNT_BITS] ? CntMax : total_sum[PRESS_COUNT_BITS-1:0];
        pend_via_d  = item_i.press_via;
        pend_park_d = item_i.press_parking;
        if (item_i.car_exit) begin
          phase_d = pelts_pkg::PH_EXIT_AMBER;
        end else if (item_i.press_via) begin
          phase_d = pelts_pkg::PH_VIA_AMBER;
        end else begin
          phase_d = pelts_pkg::PH_PARK_HOLD;
        end
      end
    end else if (count_q != '0) begin
      count_d = count_q - 1'b1;
    end else begin
      enter   = 1'b1;
      phase_d = target;
    end

    // Load the new phase length, or drop back to idle
    if (enter) begin
      if (phase_d == pelts_pkg::PH_IDLE) begin
        count_d     = '0;
        pend_via_d  = 1'b0;
        pend_park_d = 1'b0;
      end else begin
        len     = pelts_pkg::phase_is_long(phase_d) ? long_ticks_i : short_ticks_i;
        count_d = (len == '0) ? '0 : len - 1'b1;
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= pelts_pkg::PH_IDLE;
      count_q     <= '0;
      pend_via_q  <= 1'b0;
      pend_park_q <= 1'b0;
      total_q     <= '0;
    end else if (step_i) begin
      phase_q     <= phase_d;
      count_q     <= count_d;
      pend_via_q  <= pend_via_d;
      pend_park_q <= pend_park_d;
      total_q     <= total_d;
    end
  end

  // Result for this tick, from the updated state
  assign lights = pelts_pkg::phase_lights(phase_d);

  always_comb begin
    res_o.via_light          = lights.via;
    res_o.parking_light      = lights.parking;
    res_o.walk_parking_light = lights.walk_parking;
    res_o.walk_via_light     = lights.walk_via;
    res_o.ticks_left         = (phase_d == pelts_pkg::PH_IDLE) ? '0 : count_d;
    res_o.served_presses     = pelts_pkg::ServedW'(total_d);
    res_o.busy_res           = (phase_d != pelts_pkg::PH_IDLE);
  end

  // Idle carries no count and no pending request
  a_idle_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == pelts_pkg::PH_IDLE |-> count_q == '0 && !pend_via_q && !pend_park_q)
    else $error("idle phase with stale count or pending request");

  // A running sequence always serves at least one button
  a_busy_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q != pelts_pkg::PH_IDLE |-> pend_via_q || pend_park_q)
    else $error("sequence running without a pending button");

  // The phase only changes once its count has run out
  a_phase_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && phase_q != pelts_pkg::PH_IDLE && count_q != '0
    |=> phase_q == $past(phase_q) && count_q == $past(count_q) - 1'b1)
    else $error("phase left before its count ran out");

  // The served count never goes down
  a_total_mono: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> total_q >= $past(total_q))
    else $error("served press count decreased");

endmodule

// File: design/parking_exit_traffic_light_sequencer_core.sv
// A tick request waits in the input register; its result is registered in the result
// register. Throughput: one tick per cycle while the result register is free or being
// emptied; the phase update between the two registers is combinational.
// Reset: asynchronous, active low; the sequencer goes idle, the served count clears
// and the phase lengths return to 6 and 11 ticks.
module parking_exit_traffic_light_sequencer_core #(
  parameter int unsigned PRESS_COUNT_BITS = pelts_pkg::PressCountBits
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pelts_pkg::in_t                 in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pelts_pkg::out_t                out_data_o,
  input  logic                           cfg_we_i,
  input  logic [pelts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pelts_pkg::TickW-1:0]    cfg_data_i
);

  logic                          in_valid_q;
  pelts_pkg::in_t                in_data_q;
  logic                          out_valid_q;
  pelts_pkg::out_t               out_data_q;
  logic [pelts_pkg::TickW-1:0]   short_q, long_q;
  logic                          advance;
  pelts_pkg::out_t               res;

  // Move a request on when the result register is free or being emptied
  assign advance    = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || advance;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_q <= pelts_pkg::ShortTicksRst;
      long_q  <= pelts_pkg::LongTicksRst;
    end else if (cfg_we_i) begin
      case (pelts_pkg::cfg_reg_e'(cfg_idx_i))
        pelts_pkg::CFG_SHORT_TICKS: short_q <= cfg_data_i;
        pelts_pkg::CFG_LONG_TICKS:  long_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_data_q <= in_data_i;
    end
  end

  pelts_seq #(
    .PRESS_COUNT_BITS(PRESS_COUNT_BITS)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (advance),
    .item_i       (in_data_q),
    .short_ticks_i(short_q),
    .long_ticks_i (long_q),
    .res_o        (res)
  );

  // Result register: hold until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: tb/sv/light_sequence_checker.sv
`timescale 1ns / 1ps

module light_sequence_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  pelts_pkg::in_t                in_data_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  pelts_pkg::out_t               out_data_i,
  input  logic                          cfg_we_i,
  input  logic [pelts_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [pelts_pkg::TickW-1:0]   cfg_data_i,
  output int                            mismatch_cnt_o,
  output int                            lights_due_o,
  output int                            idle_samples_o
);
  import pelts_pkg::*;

  localparam logic [32:0] PressCap = (33'd1 << PressCountBits) - 33'd1;

  // Predicted sequencer state and phase lengths
  phase_e           ph_q;
  logic [TickW-1:0] cnt_q;
  logic             pend_via_q;
  logic             pend_park_q;
  logic [32:0]      presses_q;
  logic [TickW-1:0] short_len_q;
  logic [TickW-1:0] long_len_q;

  out_t expected_lights[$];
  int   bad_cnt;

  // Enter a phase and load its length; idle clears the pending requests
  function automatic void start_phase(phase_e ph);
    logic [TickW-1:0] len;
    if (ph == PH_IDLE) begin
      ph_q        = PH_IDLE;
      cnt_q       = '0;
      pend_via_q  = 1'b0;
      pend_park_q = 1'b0;
    end else begin
      len = (ph == PH_VIA_CROSS || ph == PH_PARK_CROSS || ph == PH_EXIT_GO) ?
            long_len_q : short_len_q;
      if (len == '0) len = 8'd1;
      ph_q  = ph;
      cnt_q = len - 8'd1;
    end
  endfunction

  function automatic phase_e following_phase(phase_e ph);
    case (ph)
      PH_VIA_AMBER:  return PH_VIA_CROSS;
      PH_VIA_CROSS:  return PH_VIA_FLASH;
      PH_VIA_FLASH:  return pend_park_q ? PH_PARK_HOLD : PH_IDLE;
      PH_PARK_HOLD:  return PH_PARK_CROSS;
      PH_PARK_CROSS: return PH_PARK_FLASH;
      PH_EXIT_AMBER: return PH_EXIT_GO;
      PH_EXIT_GO:    return PH_EXIT_FLASH;
      PH_EXIT_FLASH: begin
        if (pend_via_q) return PH_VIA_AMBER;
        return pend_park_q ? PH_PARK_HOLD : PH_IDLE;
      end
      default:       return PH_IDLE;
    endcase
  endfunction

  // Advance the sequencer by one tick and give the lights it shows
  function automatic out_t advance_tick(in_t req);
    out_t       r;
    logic [1:0] add;
    if (ph_q == PH_IDLE) begin
      if (req.press_via || req.press_parking) begin
        add = {1'b0, req.press_via} + {1'b0, req.press_parking};
        presses_q = (presses_q + 33'(add) > PressCap) ? PressCap : presses_q + 33'(add);
        if (req.car_exit) begin
          start_phase(PH_EXIT_AMBER);
        end else if (req.press_via) begin
          start_phase(PH_VIA_AMBER);
        end else begin
          start_phase(PH_PARK_HOLD);
        end
        pend_via_q  = req.press_via;
        pend_park_q = req.press_parking;
      end
    end else if (cnt_q != '0) begin
      cnt_q = cnt_q - 8'd1;
    end else begin
      start_phase(following_phase(ph_q));
    end

    case (ph_q)
      PH_VIA_AMBER, PH_EXIT_AMBER: begin
        r.via_light = LIGHT_AMBER; r.parking_light = LIGHT_RED;
        r.walk_parking_light = WALK_RED; r.walk_via_light = WALK_RED;
      end
      PH_VIA_CROSS: begin
        r.via_light = LIGHT_RED; r.parking_light = LIGHT_GREEN;
        r.walk_parking_light = WALK_RED; r.walk_via_light = WALK_GREEN;
      end
      PH_VIA_FLASH: begin
        r.via_light = LIGHT_FLASH; r.parking_light = LIGHT_AMBER;
        r.walk_parking_light = WALK_RED; r.walk_via_light = WALK_FLASH;
      end
      PH_PARK_CROSS: begin
        r.via_light = LIGHT_GREEN; r.parking_light = LIGHT_RED;
        r.walk_parking_light = WALK_GREEN; r.walk_via_light = WALK_RED;
      end
      PH_PARK_FLASH: begin
        r.via_light = LIGHT_GREEN; r.parking_light = LIGHT_FLASH;
        r.walk_parking_light = WALK_FLASH; r.walk_via_light = WALK_RED;
      end
      PH_EXIT_GO: begin
        r.via_light = LIGHT_RED; r.parking_light = LIGHT_GREEN;
        r.walk_parking_light = WALK_RED; r.walk_via_light = WALK_RED;
      end
      PH_EXIT_FLASH: begin
        r.via_light = LIGHT_FLASH; r.parking_light = LIGHT_AMBER;
        r.walk_parking_light = WALK_RED; r.walk_via_light = WALK_RED;
      end
      default: begin
        // idle and parking hold both keep the via road flowing
        r.via_light = LIGHT_GREEN; r.parking_light = LIGHT_RED;
        r.walk_parking_light = WALK_RED; r.walk_via_light = WALK_RED;
      end
    endcase
    r.ticks_left     = (ph_q == PH_IDLE) ? '0 : cnt_q;
    r.served_presses = presses_q[ServedW-1:0];
    r.busy_res       = (ph_q != PH_IDLE);
    return r;
  endfunction

  // Compare results, track register writes, predict each accepted request
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q        = PH_IDLE;
      cnt_q       = '0;
      pend_via_q  = 1'b0;
      pend_park_q = 1'b0;
      presses_q   = '0;
      short_len_q = ShortTicksRst;
      long_len_q  = LongTicksRst;
      bad_cnt     = 0;
      expected_lights.delete();
      mismatch_cnt_o <= 0;
      lights_due_o   <= 0;
      idle_samples_o <= 0;
    end else begin : watch
      out_t want;
      if (out_valid_i && out_ready_i) begin
        if (expected_lights.size() == 0) begin
          if (bad_cnt < 10) $display("lights result with no tick outstanding: %h", out_data_i);
          bad_cnt++;
        end else begin
          want = expected_lights.pop_front();
          if (out_data_i.via_light          != want.via_light          ||
              out_data_i.parking_light      != want.parking_light      ||
              out_data_i.walk_parking_light != want.walk_parking_light ||
              out_data_i.walk_via_light     != want.walk_via_light     ||
              out_data_i.ticks_left         != want.ticks_left         ||
              out_data_i.served_presses     != want.served_presses     ||
              out_data_i.busy_res           != want.busy_res) begin
            if (bad_cnt < 10) begin
              $display("lights mismatch exp: via=%0d park=%0d wpark=%0d wvia=%0d left=%0d srv=%0d busy=%0d",
                       want.via_light, want.parking_light, want.walk_parking_light,
                       want.walk_via_light, want.ticks_left, want.served_presses,
                       want.busy_res);
              $display("lights mismatch got: via=%0d park=%0d wpark=%0d wvia=%0d left=%0d srv=%0d busy=%0d",
                       out_data_i.via_light, out_data_i.parking_light,
                       out_data_i.walk_parking_light, out_data_i.walk_via_light,
                       out_data_i.ticks_left, out_data_i.served_presses,
                       out_data_i.busy_res);
            end
            bad_cnt++;
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          CFG_SHORT_TICKS: short_len_q = cfg_data_i;
          CFG_LONG_TICKS:  long_len_q  = cfg_data_i;
          default: ;
        endcase
      end

      if (in_valid_i && in_ready_i) begin
        if (ph_q == PH_IDLE) idle_samples_o <= idle_samples_o + 1;
        expected_lights.push_back(advance_tick(in_data_i));
      end

      mismatch_cnt_o <= bad_cnt;
      lights_due_o   <= expected_lights.size();
    end
  end

endmodule

// File: tb/sv/tb_parking_exit_traffic_light_sequencer_core.sv
`timescale 1ns / 1ps

module tb_parking_exit_traffic_light_sequencer_core;
  import pelts_pkg::*;

  localparam int unsigned LongHold    = 200;
  localparam int unsigned DrainLimit  = 20000;
  localparam int unsigned PhaseTarget = 10;

  logic                clk      = 1'b0;
  logic                rst_n    = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  in_t                 in_data  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_t                out_data;
  logic                cfg_we   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx  = CFG_SHORT_TICKS;
  logic [TickW-1:0]    cfg_data = '0;

  int          mismatch_cnt;
  int          lights_due;
  int          idle_samples;
  int unsigned hold_reqs = 0;
  bit          idle_on   = 1'b1;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  parking_exit_traffic_light_sequencer_core u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_data_i  (cfg_data)
  );

  light_sequence_checker u_check (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_i     (in_ready),
    .in_data_i      (in_data),
    .out_valid_i    (out_valid),
    .out_ready_i    (out_ready),
    .out_data_i     (out_data),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .mismatch_cnt_o (mismatch_cnt),
    .lights_due_o   (lights_due),
    .idle_samples_o (idle_samples)
  );

  // Mostly no gap, sometimes a short one, rarely a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic in_t rand_tick(bit force_req);
    in_t d;
    d = in_t'(3'($urandom_range(0, 7)));
    if (force_req && !(d.press_via || d.press_parking)) begin
      d.press_parking = 1'b1;
    end else if (!force_req && $urandom_range(0, 3) == 0) begin
      d = '0;
    end
    return d;
  endfunction

  // Offer one tick request and hold it until accepted; valid stays high between back-to-back requests
  task automatic send_tick(input in_t d);
    int unsigned g;
    g = idle_on ? pick_gap() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Stop offering and wait until every predicted result has been taken
  task automatic drain_requests();
    int unsigned n;
    in_valid <= 1'b0;
    n = 0;
    @(posedge clk);
    while (lights_due != 0 && n < DrainLimit) begin
      @(posedge clk);
      n++;
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic set_lengths(input logic [TickW-1:0] short_len, input logic [TickW-1:0] long_len);
    cfg_we   <= 1'b1;
    cfg_idx  <= CFG_SHORT_TICKS;
    cfg_data <= short_len;
    @(posedge clk);
    cfg_idx  <= CFG_LONG_TICKS;
    cfg_data <= long_len;
    @(posedge clk);
    cfg_we <= 1'b0;
    repeat (2) @(posedge clk);
  endtask

  // Result side: random stalls, plus a long hold-off on request
  initial begin : rx_side
    int unsigned gap_left;
    int unsigned hold_left;
    int unsigned holds_seen;
    gap_left   = 0;
    hold_left  = 0;
    holds_seen = 0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_reqs != holds_seen) begin
        holds_seen++;
        hold_left = LongHold;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (gap_left > 0) begin
        gap_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if (idle_on) gap_left = pick_gap();
      end
    end
  end

  // Stimulus and verdict
  initial begin : stim
    int unsigned      g;
    int unsigned      start;
    int unsigned      target;
    logic [TickW-1:0] s_len;
    logic [TickW-1:0] l_len;
    in_t              req;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    // Reset lengths: an empty tick, then a parking request run to its end
    send_tick('0);
    req = '0;
    req.press_parking = 1'b1;
    send_tick(req);
    repeat (23) send_tick(rand_tick(1'b0));
    drain_requests();

    // Zero lengths act as one; walk every request combination, noise while busy
    set_lengths('0, '0);
    for (int c = 1; c < 8; c++) begin
      req = in_t'(3'(c));
      g = 32'(req.press_via) + 32'(req.press_parking) +
          32'(req.car_exit && (req.press_via || req.press_parking));
      send_tick(req);
      repeat (3 * g) send_tick(rand_tick(1'b0));
    end
    // let a sequence started by the noise run out
    repeat (10) send_tick('0);
    drain_requests();

    // Full-length short phase: via amber counts down from the top
    set_lengths(8'd255, 8'd1);
    req = '0;
    req.press_via = 1'b1;
    send_tick(req);
    repeat (255) send_tick('0);
    drain_requests();

    // Full-length crossing: finish the via sequence, then run one more
    set_lengths(8'd1, 8'd255);
    repeat (2) send_tick('0);
    send_tick(req);
    repeat (258) send_tick('0);

    // Random phases at several length settings
    for (int k = 0; k < 9; k++) begin
      drain_requests();
      if (k == 0) begin
        s_len  = 8'd1;
        l_len  = 8'd1;
        target = 4 * PhaseTarget;
      end else begin
        s_len  = TickW'($urandom_range(1, 4));
        l_len  = TickW'($urandom_range(1, 6));
        target = PhaseTarget;
      end
      set_lengths(s_len, l_len);
      idle_on <= (k % 3 != 2);
      // hold the result side off long enough for the block to back up
      if (k == 4) hold_reqs <= hold_reqs + 1;
      start = idle_samples;
      while (idle_samples - start < target) send_tick(rand_tick(1'b0));
    end

    drain_requests();
    idle_on <= 1'b1;
    repeat (100) send_tick(rand_tick(1'b0));

    drain_requests();
    repeat (10) @(posedge clk);
    if (mismatch_cnt == 0 && lights_due == 0) begin
      $display("tb_parking_exit_traffic_light_sequencer_core OK");
    end else begin
      $display("tb_parking_exit_traffic_light_sequencer_core NOT OK");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20_000_000;
    $display("tb_parking_exit_traffic_light_sequencer_core NOT OK");
    $finish;
  end

endmodule
